@@ rtl/core/pli_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int MaxPointsDef = 16;
  localparam int MinPoints    = 2;
  localparam int FracBits     = 16;
  localparam int ValW         = 32;
  localparam int CountW       = 5;
  localparam int IndexW       = 4;

  localparam logic [CountW-1:0] CountRst = CountW'(MinPoints);

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_MUL,
    S_ADD
  } state_e;

endpackage

@@ rtl/core/piecewise_linear_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table (x, y) in Q16.16 with linear interpolation between the
// two entries that bracket a query.
//
//   channel   direction  handshake                 payload
//   request   in         start, busy               req_type, point_index,
//                                                  point_x, point_y, query_x
//   result    out        done_o (one-cycle strobe) height_o
//   config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (point count)
//
// A load leaves busy low. A query scans the table entries in use, one entry
// per cycle through the RAM read port, then runs a 16-step restoring divider,
// one multiply and one add; it skips these when the query falls outside the
// table. Reset clears control state only; table contents are undefined until
// loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
  parameter int MaxPoints = pli_pkg::MaxPointsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type_i,
  input  logic [pli_pkg::IndexW-1:0]   point_index_i,
  input  logic signed [pli_pkg::ValW-1:0] point_x_i,
  input  logic signed [pli_pkg::ValW-1:0] point_y_i,
  input  logic signed [pli_pkg::ValW-1:0] query_x_i,
  output logic                         done_o,
  output logic signed [pli_pkg::ValW-1:0] height_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pli_pkg::CountW-1:0]   cfg_data_i
);

  import pli_pkg::*;

  localparam int AW    = $clog2(MaxPoints);
  localparam int CW    = $clog2(MaxPoints + 1);
  localparam int StepW = $clog2(FracBits);
  localparam int DW    = ValW + 1;
  localparam int PW    = DW + FracBits + 1;

  state_e state_q, state_d;

  logic [CountW-1:0]   pcount_q;
  logic [CW-1:0]       n_q, n_d, n_clamp;
  logic [CW-1:0]       cnt_q, cnt_d, didx_q, didx_d;
  logic                dv_q, dv_d;
  logic signed [ValW-1:0] q_q, q_d;
  logic [2*ValW-1:0]   prev_q, prev_d;
  logic [DW-1:0]       rem_q, rem_d, den_q, den_d;
  logic signed [DW-1:0] dy_q, dy_d;
  logic signed [ValW-1:0] y0_q, y0_d;
  logic [FracBits-1:0] quo_q, quo_d;
  logic [StepW-1:0]    step_q, step_d;
  logic signed [ValW-1:0] prod_q, prod_d;
  logic                valid_q, valid_d;
  logic signed [ValW-1:0] height_q, height_d;

  logic                accept, is_query, is_load;
  logic                we, re;
  logic [2*ValW-1:0]   rdata;
  logic signed [ValW-1:0] cur_x, cur_y, prev_x, prev_y;
  logic                gt, first_hit, last_miss, div_last;
  logic [DW:0]         shifted;
  logic                ge;
  logic signed [PW-1:0] prod;

  assign accept   = start && !busy;
  assign is_query = req_type_i == REQ_QUERY;
  assign is_load  = req_type_i == REQ_LOAD;
  assign busy     = state_q != S_IDLE;
  assign cfg_ready_o = !busy;

  always_comb begin
    if (32'(pcount_q) > MaxPoints) begin
      n_clamp = CW'(MaxPoints);
    end else if (32'(pcount_q) < MinPoints) begin
      n_clamp = CW'(MinPoints);
    end else begin
      n_clamp = CW'(pcount_q);
    end
  end

  // Loads only happen while idle, so a scan never reads an entry in flight.
  assign we = accept && is_load && (32'(point_index_i) < MaxPoints);
  assign re = (state_q == S_SCAN) && (cnt_q < n_q);

  pli_ram #(
    .Width (2 * ValW),
    .Depth (MaxPoints)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(point_index_i)),
    .wdata_i ({point_x_i, point_y_i}),
    .re_i    (re),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign cur_x  = rdata[2*ValW-1:ValW];
  assign cur_y  = rdata[ValW-1:0];
  assign prev_x = prev_q[2*ValW-1:ValW];
  assign prev_y = prev_q[ValW-1:0];

  assign gt        = dv_q && (cur_x > q_q);
  assign first_hit = gt && (didx_q == '0);
  assign last_miss = dv_q && !gt && (didx_q == n_q - CW'(1));
  assign div_last  = step_q == StepW'(FracBits - 1);

  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};
  assign prod    = dy_q * $signed({1'b0, quo_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && is_query) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (first_hit || last_miss) begin
          state_d = S_IDLE;
        end else if (gt) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_d      = n_q;
    cnt_d    = cnt_q;
    didx_d   = didx_q;
    dv_d     = 1'b0;
    q_d      = q_q;
    prev_d   = prev_q;
    rem_d    = rem_q;
    den_d    = den_q;
    dy_d     = dy_q;
    y0_d     = y0_q;
    quo_d    = quo_q;
    step_d   = step_q;
    prod_d   = prod_q;
    valid_d  = 1'b0;
    height_d = height_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && is_query) begin
          n_d   = n_clamp;
          cnt_d = '0;
          q_d   = query_x_i;
        end
      end
      S_SCAN: begin
        if (re) begin
          cnt_d  = cnt_q + CW'(1);
          dv_d   = 1'b1;
          didx_d = cnt_q;
        end
        if (first_hit || last_miss) begin
          height_d = cur_y;
          valid_d  = 1'b1;
        end else if (gt) begin
          rem_d  = DW'({q_q[ValW-1], q_q} - {prev_x[ValW-1], prev_x});
          den_d  = DW'({cur_x[ValW-1], cur_x} - {prev_x[ValW-1], prev_x});
          dy_d   = DW'({cur_y[ValW-1], cur_y} - {prev_y[ValW-1], prev_y});
          y0_d   = prev_y;
          quo_d  = '0;
          step_d = '0;
        end else if (dv_q) begin
          prev_d = rdata;
        end
      end
      S_DIV: begin
        if (ge) begin
          rem_d = DW'(shifted - {1'b0, den_q});
        end else begin
          rem_d = shifted[DW-1:0];
        end
        quo_d  = {quo_q[FracBits-2:0], ge};
        step_d = step_q + StepW'(1);
      end
      S_MUL: begin
        prod_d = prod[FracBits +: ValW];
      end
      S_ADD: begin
        height_d = y0_q + prod_q;
        valid_d  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pcount_q <= CountRst;
      valid_q  <= 1'b0;
      dv_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      dv_q    <= dv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pcount_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    cnt_q    <= cnt_d;
    didx_q   <= didx_d;
    q_q      <= q_d;
    prev_q   <= prev_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
    dy_q     <= dy_d;
    y0_q     <= y0_d;
    quo_q    <= quo_d;
    step_q   <= step_d;
    prod_q   <= prod_d;
    height_q <= height_d;
  end

  assign done_o   = valid_q;
  assign height_o = height_q;

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_query) |=> busy)
    else $error("query did not start");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load) |=> (!busy && !done_o))
    else $error("load left block busy or made a result");

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (den_q != '0 && rem_q < den_q))
    else $error("divider remainder out of range");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

@@ rtl/core/pli_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
